[hw/rtl/wma_pkg.sv]
// ----------------------------------------------------------------------------
// wma_pkg
// Shared types and constants of the weighted moment accumulator: the input
// and result items, the queue entry between front and back, and limits.
// ----------------------------------------------------------------------------
package wma_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int WEIGHT_BITS = 8;
    localparam int ORDER_W     = 3;
    localparam int COUNT_W     = 32;
    localparam int SUM_W       = 64;
    localparam int NUM_SUM_OUT = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ORDER_W-1:0] ORDER_RESET = 3'd3;

    localparam logic ACT_FILL  = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef struct packed {
        logic                          action;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] min_seen;
        logic signed [SAMPLE_BITS-1:0] max_seen;
        logic        [COUNT_W-1:0]     fill_count;
        logic signed [SUM_W-1:0]       sum_pow0;
        logic signed [SUM_W-1:0]       sum_pow1;
        logic signed [SUM_W-1:0]       sum_pow2;
        logic signed [SUM_W-1:0]       sum_pow3;
        logic signed [SUM_W-1:0]       sum_pow4;
        logic                          overflow_seen;
    } t_out_item;

    // One classified item as it waits between front and back.
    typedef struct packed {
        logic                          is_clear;
        logic        [ORDER_W-1:0]     order;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [WEIGHT_BITS-1:0] weight;
    } t_op;

endpackage

[hw/rtl/wma_front.sv]
// ----------------------------------------------------------------------------
// wma_front
// Accepts input items, classifies them as clear or fill, clamps the
// configured order to the built-in limit and pushes them into the queue.
// ----------------------------------------------------------------------------
module wma_front #(
    parameter int MAX_ORDER = 4
) (
    input  logic                           i_in_valid,
    input  wma_pkg::t_in_item              i_in_data,
    output logic                           o_in_stall,
    input  logic [wma_pkg::ORDER_W-1:0]    i_moment_order,
    input  logic                           i_q_full,
    output logic                           o_push,
    output wma_pkg::t_op                   o_op
);
    import wma_pkg::*;

    localparam logic [ORDER_W-1:0] ORDER_LIMIT = ORDER_W'(MAX_ORDER);

    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    always_comb begin
        o_op.is_clear = (i_in_data.action == ACT_CLEAR);
        o_op.order    = (i_moment_order > ORDER_LIMIT) ? ORDER_LIMIT : i_moment_order;
        o_op.sample   = i_in_data.sample;
        o_op.weight   = i_in_data.weight;
    end

endmodule

[hw/rtl/wma_queue.sv]
// ----------------------------------------------------------------------------
// wma_queue
// Short first-in first-out queue of classified items between the front and
// the back, so that each side can stall on its own.
// ----------------------------------------------------------------------------
module wma_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wma_pkg::t_op  i_op,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output wma_pkg::t_op  o_op
);
    import wma_pkg::*;

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

    t_op           r_mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] n_wr;
    logic [PW-1:0] n_rd;
    logic [CW-1:0] n_cnt;

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("item pushed into a full queue");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("item popped from an empty queue");

endmodule

[hw/rtl/wma_back.sv]
// ----------------------------------------------------------------------------
// wma_back
// Carries out queued items: clears the statistics or performs one fill.
// A fill walks the powers one order at a time, forming w*x^k from the
// previous term as two partial products of its 32-bit halves, and adds each
// term into its saturating 64-bit sum. An output register holds the result.
// ----------------------------------------------------------------------------
module wma_back #(
    parameter int MAX_ORDER = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  wma_pkg::t_op       i_q_op,
    output logic               o_q_pop,
    output logic               o_out_valid,
    output wma_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);
    import wma_pkg::*;

    localparam int KW     = (MAX_ORDER > 0) ? $clog2(MAX_ORDER + 1) : 1;
    localparam int PH_W   = 32 + SAMPLE_BITS;
    localparam int PL_W   = 33 + SAMPLE_BITS;
    localparam int PROD_W = SUM_W + SAMPLE_BITS + 1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_NORM = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                    r_state,   n_state;
    t_op                           r_op,      n_op;
    logic [KW-1:0]                 r_k,       n_k;
    logic signed [SUM_W-1:0]       r_term,    n_term;
    logic                          r_tov,     n_tov;
    logic signed [PH_W-1:0]        r_p_hi,    n_p_hi;
    logic signed [PL_W-1:0]        r_p_lo,    n_p_lo;
    logic signed [SAMPLE_BITS-1:0] r_min,     n_min;
    logic signed [SAMPLE_BITS-1:0] r_max,     n_max;
    logic [COUNT_W-1:0]            r_cnt,     n_cnt;
    logic signed [SUM_W-1:0]       r_sum [0:MAX_ORDER];
    logic signed [SUM_W-1:0]       n_sum [0:MAX_ORDER];
    logic                          r_ovf,     n_ovf;
    logic                          r_o_valid, n_o_valid;
    t_out_item                     r_o_data,  n_o_data;

    logic signed [SUM_W-1:0]       sum_view [0:NUM_SUM_OUT-1];
    logic [SUM_W:0]                acc_wide;
    logic                          acc_ovf;
    logic signed [SUM_W-1:0]       acc_val;
    logic [PROD_W-1:0]             prod;
    logic                          prod_fits;
    logic                          sat_neg;

    // Sums above the built-in order read as zero.
    for (genvar g = 0; g < NUM_SUM_OUT; g++) begin : g_view
        if (g <= MAX_ORDER) begin : g_on
            assign sum_view[g] = r_sum[g];
        end else begin : g_off
            assign sum_view[g] = '0;
        end
    end

    always_comb begin
        acc_wide = {r_sum[r_k][SUM_W-1], r_sum[r_k]} + {r_term[SUM_W-1], r_term};
        acc_ovf  = acc_wide[SUM_W] ^ acc_wide[SUM_W-1];
        acc_val  = acc_ovf ? (acc_wide[SUM_W] ? SUM_MIN : SUM_MAX) : acc_wide[SUM_W-1:0];
    end

    // The previous term is split into a signed upper and an unsigned lower half.
    always_comb begin
        prod = {{(PROD_W-PH_W-32){r_p_hi[PH_W-1]}}, r_p_hi, 32'b0}
             + {{(PROD_W-PL_W){r_p_lo[PL_W-1]}}, r_p_lo};
        prod_fits = (&prod[PROD_W-1:SUM_W-1]) || !(|prod[PROD_W-1:SUM_W-1]);
        // Once a term has clamped, all later ones do; sign: previous term times x.
        sat_neg = r_tov ? (r_term[SUM_W-1] ^ r_op.sample[SAMPLE_BITS-1]) : prod[PROD_W-1];
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_k       = r_k;
        n_term    = r_term;
        n_tov     = r_tov;
        n_p_hi    = r_p_hi;
        n_p_lo    = r_p_lo;
        n_min     = r_min;
        n_max     = r_max;
        n_cnt     = r_cnt;
        n_sum     = r_sum;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid;
        n_o_data  = r_o_data;
        o_q_pop   = 1'b0;

        if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_op;
                    n_tov   = 1'b0;
                    n_k     = '0;
                    if (i_q_op.is_clear) begin
                        n_min = SAMPLE_MAX;
                        n_max = SAMPLE_MIN;
                        n_cnt = '0;
                        n_ovf = 1'b0;
                        for (int j = 0; j <= MAX_ORDER; j++) begin
                            n_sum[j] = '0;
                        end
                        n_state = S_DONE;
                    end else begin
                        if (!i_q_op.weight[WEIGHT_BITS-1]) begin
                            if ($signed(i_q_op.sample) < r_min) begin
                                n_min = i_q_op.sample;
                            end
                            if ($signed(i_q_op.sample) > r_max) begin
                                n_max = i_q_op.sample;
                            end
                        end
                        if (r_cnt != '1) begin
                            n_cnt = r_cnt + 1'b1;
                        end
                        n_term  = SUM_W'(i_q_op.weight);
                        n_state = S_ACC;
                    end
                end
            end
            S_ACC: begin
                n_sum[r_k] = acc_val;
                n_ovf      = r_ovf || r_tov || acc_ovf;
                if (ORDER_W'(r_k) == r_op.order) begin
                    n_state = S_DONE;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_p_hi  = $signed(r_term[SUM_W-1:32]) * r_op.sample;
                n_p_lo  = $signed({1'b0, r_term[31:0]}) * r_op.sample;
                n_state = S_NORM;
            end
            S_NORM: begin
                if (r_tov || !prod_fits) begin
                    n_tov  = 1'b1;
                    n_term = sat_neg ? SUM_MIN : SUM_MAX;
                end else begin
                    n_term = prod[SUM_W-1:0];
                end
                n_state = S_ACC;
            end
            S_DONE: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid              = 1'b1;
                    n_o_data.min_seen      = r_min;
                    n_o_data.max_seen      = r_max;
                    n_o_data.fill_count    = r_cnt;
                    n_o_data.sum_pow0      = sum_view[0];
                    n_o_data.sum_pow1      = sum_view[1];
                    n_o_data.sum_pow2      = sum_view[2];
                    n_o_data.sum_pow3      = sum_view[3];
                    n_o_data.sum_pow4      = sum_view[4];
                    n_o_data.overflow_seen = r_ovf;
                    n_state                = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_k       <= '0;
            r_tov     <= 1'b0;
            r_min     <= SAMPLE_MAX;
            r_max     <= SAMPLE_MIN;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
            for (int j = 0; j <= MAX_ORDER; j++) begin
                r_sum[j] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_tov     <= n_tov;
            r_min     <= n_min;
            r_max     <= n_max;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
            r_sum     <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_term   <= n_term;
        r_p_hi   <= n_p_hi;
        r_p_lo   <= n_p_lo;
        r_o_data <= n_o_data;
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    a_k_within_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC || r_state == S_MUL || r_state == S_NORM)
            |-> (ORDER_W'(r_k) <= r_op.order))
        else $error("power index ran past the order of the item");

    a_clear_restores: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_q_valid && i_q_op.is_clear)
            |=> (r_cnt == '0 && !r_ovf && r_state == S_DONE))
        else $error("clear did not restore the statistics");

    a_clamp_needs_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tov |-> (!r_op.is_clear && r_op.weight != '0))
        else $error("term clamped on a clear or a zero weight");

    a_done_loads_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && (!r_o_valid || !i_out_stall))
            |=> (r_o_valid && r_state == S_IDLE))
        else $error("finished item did not reach the output register");

endmodule

[hw/rtl/weighted_moment_accumulator.sv]
// ----------------------------------------------------------------------------
// weighted_moment_accumulator
// Running minimum, maximum, fill count and weighted power sums of a stream
// of weighted samples, with saturating 64-bit sums and a sticky overflow flag.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on i_in_valid / i_in_data and are taken at an edge where
// o_in_stall is low. Action fill adds the sample and weight to the statistics;
// action clear restores them. Every item returns one result item on
// o_out_valid / o_out_data, holding the statistics after that item; the
// receiver holds it with i_out_stall and it stays unchanged meanwhile.
// i_cfg_we writes i_cfg_wdata into the moment order; values above MAX_ORDER
// act as MAX_ORDER. Write it only while no item is in flight.
// Flow: a fill of effective order K accumulates power zero, then takes one
// multiply, one normalize and one accumulate step per power up to K; a
// clear resets the statistics and goes straight to the result. With the
// back end idle, it takes an item from the two-entry queue in the cycle
// after it is accepted. The queue keeps accepting items while the back end
// works or waits on a stalled result, until it is full.
// Reset (synchronous, active low) sets the order to 3, the minimum to the
// most positive and the maximum to the most negative sample, and clears
// the count, the sums and the overflow flag.
// ----------------------------------------------------------------------------
module weighted_moment_accumulator #(
    parameter int MAX_ORDER = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  wma_pkg::t_in_item            i_in_data,
    output logic                         o_in_stall,
    output logic                         o_out_valid,
    output wma_pkg::t_out_item           o_out_data,
    input  logic                         i_out_stall,
    input  logic                         i_cfg_we,
    input  logic [wma_pkg::ORDER_W-1:0]  i_cfg_wdata
);
    import wma_pkg::*;

    logic [ORDER_W-1:0] r_moment_order;
    logic               q_full;
    logic               q_push;
    logic               q_valid;
    logic               q_pop;
    t_op                q_in_op;
    t_op                q_out_op;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_moment_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_moment_order <= i_cfg_wdata;
        end
    end

    wma_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .o_in_stall     (o_in_stall),
        .i_moment_order (r_moment_order),
        .i_q_full       (q_full),
        .o_push         (q_push),
        .o_op           (q_in_op)
    );

    wma_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (q_in_op),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_out_op)
    );

    wma_back #(
        .MAX_ORDER (MAX_ORDER)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_op      (q_out_op),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule
